@@ sv/tgarle_pkg.sv @@
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types, codes and helpers of the run-length targa pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

   // pixel format codes; 6 and 7 decode as bgr24
   typedef enum logic [2:0] {
      FMT_RGB15    = 3'd0,
      FMT_BGR24    = 3'd1,
      FMT_BGRA32   = 3'd2,
      FMT_GRAY8    = 3'd3,
      FMT_GRAYA16  = 3'd4,
      FMT_PALETTE8 = 3'd5
   } fmt_type;

   // configuration register indexes
   localparam logic CSR_PIXEL_FORMAT = 1'b0;
   localparam logic CSR_PIXEL_TOTAL  = 1'b1;

   // request modes
   localparam logic MODE_STREAM    = 1'b0;
   localparam logic MODE_PAL_WRITE = 1'b1;

   localparam logic [2:0]  FORMAT_RESET = 3'd1;
   localparam logic [31:0] TOTAL_RESET  = 32'd1;
   localparam logic [7:0]  COUNT_MASK   = 8'h7F;
   localparam int          RUN_FLAG_BIT = 7;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

   function automatic logic [2:0] bytes_per_pixel(input logic [2:0] fmt);
      logic [2:0] n;
      unique case (fmt)
         FMT_RGB15:    n = 3'd2;
         FMT_BGRA32:   n = 3'd4;
         FMT_GRAY8:    n = 3'd1;
         FMT_GRAYA16:  n = 3'd2;
         FMT_PALETTE8: n = 3'd1;
         default:      n = 3'd3;
      endcase
      return n;
   endfunction

endpackage

@@ sv/tgarle_palette_ram.sv @@
// ----------------------------------------------------------------------------
// tgarle_palette_ram
// Palette color store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tgarle_palette_ram import tgarle_pkg::*; #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(PALETTE_DEPTH)-1:0] wr_addr,
   input  logic [23:0]                      wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(PALETTE_DEPTH)-1:0] rd_addr,
   output logic [23:0]                      rd_data
);

   logic [23:0] mem_ff [PALETTE_DEPTH];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/tga_rle_pixel_decoder_top.sv @@
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// Run-length targa packet decoder: one stream byte per beat in, one colored
// run per complete pixel out.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  mode, data_byte, palette index/color
//  rsp      out        rsp_valid/rsp_stall  red, green, blue, alpha, repeat, last
//  csr      in         csr_write_en         index, data (write only)
//
//  one beat accepted per cycle while req_stall is low; a pixel is registered
//  in the unpack stage with its palette read, then unpacked into output register
//  synchronous reset restores format bgr24 and a one-pixel image; the palette
//  is not cleared and has no clearing pass
//  req_stall rises only when the unpack stage holds a pixel and the output
//  register is stalled
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top import tgarle_pkg::*; #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_palette_index,
   input  logic [23:0] req_palette_color,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [7:0]  rsp_repeat_count,
   output logic        rsp_last_run,

   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int AW = $clog2(PALETTE_DEPTH);

   // configuration
   logic [2:0]  fmt_ff;
   logic [31:0] total_ff;

   // packet state
   logic [7:0]  pkt_left_ff, pkt_left_in;
   logic        run_ff, run_in;
   logic [1:0]  pos_ff, pos_in;
   logic [23:0] pb_ff, pb_in;
   logic [31:0] left_ff, left_in;
   logic        done_ff, done_in;

   // unpack stage
   logic        s1_vld_ff;
   logic [31:0] s1_pix_ff;
   logic [2:0]  s1_fmt_ff;
   logic [7:0]  s1_cnt_ff;
   logic        s1_last_ff;
   logic        s1_oob_ff;

   // output register
   logic        rsp_valid_ff;
   logic [7:0]  red_ff, green_ff, blue_ff, alpha_ff, cnt_ff;
   logic        last_ff;

   logic        out_free, accept, stream, hdr, pix_byte, pix_done, final_byte;
   logic [2:0]  bpp;
   logic [31:0] pb_full;
   logic [7:0]  cnt_raw, cnt;
   logic        clamp;
   logic        pal_rd_en, pal_wr_en, idx_oob;
   logic [23:0] pal_rd_data;
   logic [7:0]  red_in, green_in, blue_in, alpha_in;
   logic [31:0] restart_total;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_vld_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign stream   = accept && (req_mode == MODE_STREAM) && !done_ff;
   assign hdr      = stream && (pkt_left_ff == 8'd0);
   assign pix_byte = stream && (pkt_left_ff != 8'd0);

   assign bpp        = bytes_per_pixel(fmt_ff);
   assign final_byte = ({1'b0, pos_ff} + 3'd1) >= bpp;
   assign pix_done   = pix_byte && final_byte;

   assign pb_full = {8'd0, pb_ff} | (32'(req_data_byte) << {pos_ff, 3'b000});

   // run packets emit their whole count at once, raw packets one pixel each
   assign cnt_raw = run_ff ? pkt_left_ff : 8'd1;
   assign clamp   = {24'd0, cnt_raw} >= left_ff;
   assign cnt     = clamp ? left_ff[7:0] : cnt_raw;

   assign idx_oob   = {1'b0, req_data_byte} >= 9'(PALETTE_DEPTH);
   assign pal_rd_en = pix_done && (fmt_ff == FMT_PALETTE8) && !idx_oob;
   assign pal_wr_en = accept && (req_mode == MODE_PAL_WRITE)
                      && ({1'b0, req_palette_index} < 9'(PALETTE_DEPTH));

   tgarle_palette_ram #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (req_palette_index[AW-1:0]),
      .wr_data (req_palette_color),
      .rd_en   (pal_rd_en),
      .rd_addr (req_data_byte[AW-1:0]),
      .rd_data (pal_rd_data)
   );

   always_comb begin
      pkt_left_in = pkt_left_ff;
      run_in      = run_ff;
      pos_in      = pos_ff;
      pb_in       = pb_ff;
      left_in     = left_ff;
      done_in     = done_ff;
      if (hdr) begin
         pkt_left_in = (req_data_byte & COUNT_MASK) + 8'd1;
         run_in      = req_data_byte[RUN_FLAG_BIT];
         pos_in      = 2'd0;
         pb_in       = 24'd0;
      end else if (pix_done) begin
         pos_in      = 2'd0;
         pb_in       = 24'd0;
         pkt_left_in = run_ff ? 8'd0 : pkt_left_ff - 8'd1;
         left_in     = left_ff - 32'(cnt);
         done_in     = clamp;
      end else if (pix_byte) begin
         pos_in = pos_ff + 2'd1;
         pb_in  = pb_full[23:0];
      end
   end

   assign restart_total = (csr_index == CSR_PIXEL_TOTAL) ? csr_data : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff      <= FORMAT_RESET;
         total_ff    <= TOTAL_RESET;
         pkt_left_ff <= 8'd0;
         run_ff      <= 1'b0;
         pos_ff      <= 2'd0;
         pb_ff       <= 24'd0;
         left_ff     <= TOTAL_RESET;
         done_ff     <= 1'b0;
      end else if (csr_write_en) begin
         // any register write restarts the image; the palette stays
         if (csr_index == CSR_PIXEL_FORMAT) begin
            fmt_ff <= csr_data[2:0];
         end else begin
            total_ff <= csr_data;
         end
         pkt_left_ff <= 8'd0;
         run_ff      <= 1'b0;
         pos_ff      <= 2'd0;
         pb_ff       <= 24'd0;
         left_ff     <= restart_total;
         done_ff     <= (restart_total == 32'd0);
      end else begin
         pkt_left_ff <= pkt_left_in;
         run_ff      <= run_in;
         pos_ff      <= pos_in;
         pb_ff       <= pb_in;
         left_ff     <= left_in;
         done_ff     <= done_in;
      end
   end

   // unpack stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (pix_done) begin
         s1_vld_ff <= 1'b1;
      end else if (out_free) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_done) begin
         s1_pix_ff  <= pb_full;
         s1_fmt_ff  <= fmt_ff;
         s1_cnt_ff  <= cnt;
         s1_last_ff <= clamp;
         s1_oob_ff  <= idx_oob;
      end
   end

   always_comb begin
      alpha_in = ALPHA_OPAQUE;
      red_in   = s1_pix_ff[23:16];
      green_in = s1_pix_ff[15:8];
      blue_in  = s1_pix_ff[7:0];
      unique case (s1_fmt_ff)
         FMT_RGB15: begin
            red_in   = {s1_pix_ff[14:10], 3'b000};
            green_in = {s1_pix_ff[9:5], 3'b000};
            blue_in  = {s1_pix_ff[4:0], 3'b000};
         end
         FMT_BGRA32: begin
            alpha_in = s1_pix_ff[31:24];
         end
         FMT_GRAY8: begin
            red_in   = s1_pix_ff[7:0];
            green_in = s1_pix_ff[7:0];
            blue_in  = s1_pix_ff[7:0];
         end
         FMT_GRAYA16: begin
            red_in   = s1_pix_ff[7:0];
            green_in = s1_pix_ff[7:0];
            blue_in  = s1_pix_ff[7:0];
            alpha_in = s1_pix_ff[15:8];
         end
         FMT_PALETTE8: begin
            // index past the palette reads as black
            red_in   = s1_oob_ff ? 8'd0 : pal_rd_data[23:16];
            green_in = s1_oob_ff ? 8'd0 : pal_rd_data[15:8];
            blue_in  = s1_oob_ff ? 8'd0 : pal_rd_data[7:0];
         end
         default: begin
            alpha_in = ALPHA_OPAQUE;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_vld_ff) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         alpha_ff <= alpha_in;
         cnt_ff   <= s1_cnt_ff;
         last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red          = red_ff;
   assign rsp_green        = green_ff;
   assign rsp_blue         = blue_ff;
   assign rsp_alpha        = alpha_ff;
   assign rsp_repeat_count = cnt_ff;
   assign rsp_last_run     = last_ff;

endmodule
